// File: src/adcsa_pkg.sv
package adcsa_pkg;

  localparam int CHANNELS  = 3;
  localparam int ROUNDS    = 4;
  localparam int DATA_BITS = 24;

  localparam int CH_W      = 2;
  localparam int RD_W      = $clog2(ROUNDS);
  localparam int DEPTH     = CHANNELS * ROUNDS;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int ACC_W     = DATA_BITS + RD_W;
  localparam int CNT_W     = 16;
  localparam int ACT_W     = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // Result action codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_BEGIN   = 3'd0,
    ACT_PULSE   = 3'd1,
    ACT_SETTLE  = 3'd2,
    ACT_WAITING = 3'd3,
    ACT_STORED  = 3'd4,
    ACT_ZERO    = 3'd5,
    ACT_RESET   = 3'd6
  } act_t;

  // Conversion phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_PULSE  = 4'b0010,
    PH_SETTLE = 4'b0100,
    PH_READ   = 4'b1000
  } phase_t;

  // Datapath controls issued by the microcode.
  typedef struct packed {
    logic take;      // input port open
    logic exec;      // run one tick of the sequence
    logic out_load;  // load the result register when it is free
    logic out_avg;   // the loaded result carries an average
    logic rd_issue;  // read the sample store at the summing pointers
    logic acc_add;   // add the read sample, advance the round pointer
    logic ch_step;   // next channel of the averaging pass
  } ctl_t;

  // Conditions returned by the datapath for microcode jumps.
  typedef struct packed {
    logic in_fire;
    logic emit;
    logic out_free;
    logic rd_last;
    logic ch_last;
  } stat_t;

endpackage

// File: src/adcsa_in_if.sv
interface adcsa_in_if;
  logic                              valid;
  logic                              ready;
  logic                              data_ready;
  logic [adcsa_pkg::DATA_BITS-1:0]   adc_data;

  modport source (output valid, output data_ready, output adc_data, input ready);
  modport sink (input valid, input data_ready, input adc_data, output ready);
endinterface

// File: src/adcsa_out_if.sv
interface adcsa_out_if;
  logic                              valid;
  logic                              ready;
  logic [adcsa_pkg::ACT_W-1:0]       action;
  logic                              avg_valid;
  logic [adcsa_pkg::CH_W-1:0]        avg_channel;
  logic [adcsa_pkg::DATA_BITS-1:0]   avg_value;
  logic [adcsa_pkg::CNT_W-1:0]       reset_total;
  logic                              last;

  modport source (output valid, output action, output avg_valid, output avg_channel,
                  output avg_value, output reset_total, output last, input ready);
  modport sink (input valid, input action, input avg_valid, input avg_channel,
                input avg_value, input reset_total, input last, output ready);
endinterface

// File: src/adcsa_seq.sv
// Microcode sequencer: a step counter walks a small control ROM and takes
// conditional jumps on the status flags from the datapath.
module adcsa_seq (
  input  logic              clk,
  input  logic              rst,
  input  adcsa_pkg::stat_t  stat,
  output adcsa_pkg::ctl_t   ctl
);

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_IN       = 3'd1,
    C_EMIT     = 3'd2,
    C_OUT_FREE = 3'd3,
    C_RD_LAST  = 3'd4,
    C_CH_LAST  = 3'd5
  } cond_t;

  typedef enum logic [2:0] {
    S_FETCH  = 3'd0,
    S_EXEC   = 3'd1,
    S_PUT1   = 3'd2,
    S_ADDR   = 3'd3,
    S_ACC    = 3'd4,
    S_PUTA   = 3'd5,
    S_NEXTCH = 3'd6
  } step_t;

  typedef struct packed {
    cond_t            cond;
    step_t            tgt_t;
    step_t            tgt_f;
    adcsa_pkg::ctl_t  ctl;
  } ucw_t;

  function automatic ucw_t rom(input step_t s);
    ucw_t w;
    w = '{cond: C_IN, tgt_t: S_EXEC, tgt_f: S_FETCH, ctl: '0};
    unique case (s)
      S_FETCH: begin
        w.ctl.take = 1'b1;
      end
      S_EXEC: begin
        w = '{cond: C_EMIT, tgt_t: S_ADDR, tgt_f: S_PUT1, ctl: '0};
        w.ctl.exec = 1'b1;
      end
      S_PUT1: begin
        w = '{cond: C_OUT_FREE, tgt_t: S_FETCH, tgt_f: S_PUT1, ctl: '0};
        w.ctl.out_load = 1'b1;
      end
      S_ADDR: begin
        w = '{cond: C_ALWAYS, tgt_t: S_ACC, tgt_f: S_ACC, ctl: '0};
        w.ctl.rd_issue = 1'b1;
      end
      S_ACC: begin
        w = '{cond: C_RD_LAST, tgt_t: S_PUTA, tgt_f: S_ADDR, ctl: '0};
        w.ctl.acc_add = 1'b1;
      end
      S_PUTA: begin
        w = '{cond: C_OUT_FREE, tgt_t: S_NEXTCH, tgt_f: S_PUTA, ctl: '0};
        w.ctl.out_load = 1'b1;
        w.ctl.out_avg  = 1'b1;
      end
      S_NEXTCH: begin
        w = '{cond: C_CH_LAST, tgt_t: S_FETCH, tgt_f: S_ADDR, ctl: '0};
        w.ctl.ch_step = 1'b1;
      end
      default: begin
        w = '{cond: C_ALWAYS, tgt_t: S_FETCH, tgt_f: S_FETCH, ctl: '0};
      end
    endcase
    return w;
  endfunction

  step_t step;
  step_t step_next;
  ucw_t  word;
  logic  hit;

  always_comb begin
    word = rom(step);
    unique case (word.cond)
      C_ALWAYS:   hit = 1'b1;
      C_IN:       hit = stat.in_fire;
      C_EMIT:     hit = stat.emit;
      C_OUT_FREE: hit = stat.out_free;
      C_RD_LAST:  hit = stat.rd_last;
      C_CH_LAST:  hit = stat.ch_last;
      default:    hit = 1'b1;
    endcase
    step_next = hit ? word.tgt_t : word.tgt_f;
    ctl       = word.ctl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: src/adc_scan_average_sequencer_top.sv
// ADC scan-and-average sequencer. Each input transfer is one timer tick that
// carries the converter's data-ready level and its data word. The block walks
// the conversion sequence (begin, start pulse, settle, read) over three
// channels and keeps four rounds of samples per channel. Each tick yields one
// result transfer, except the read that closes the fourth round, which yields
// three: the truncated average of the four stored samples of channels 0, 1
// and 2, in that order, with last set on the third. A zero reading is not
// stored but still advances the scan. When data-ready stays low on more
// consecutive read ticks than miss_limit allows, the block reports a
// converter reset, clears its sequence state and sample store, and counts
// the reset in a saturating counter. Control is a microcoded sequencer: a
// step counter runs a seven-word control ROM. A tick that yields one result
// is accepted, executed and written to the result register. A tick that
// yields the averages runs a pass that reads the store through its single
// registered read port, a read and an add per sample, four samples per
// channel, plus a result and a pointer step per channel. Stalls at the
// output hold up both. The next tick is accepted while the last result
// still waits in the output register. miss_limit is to be written through
// cfg_we and cfg_wdata only while the block is idle; the block does not check.
module adc_scan_average_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  adcsa_in_if.sink                      in_ch,
  adcsa_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [adcsa_pkg::CNT_W-1:0]   cfg_wdata
);

  adcsa_pkg::ctl_t   ctl;
  adcsa_pkg::stat_t  stat;

  // Configuration register.
  logic [adcsa_pkg::CNT_W-1:0] miss_limit;

  // Sequence state.
  adcsa_pkg::phase_t              phase;
  logic [adcsa_pkg::CH_W-1:0]     chan;
  logic [adcsa_pkg::RD_W-1:0]     rnd;
  logic [adcsa_pkg::CNT_W-1:0]    miss_count;
  logic [adcsa_pkg::CNT_W-1:0]    reset_count;
  adcsa_pkg::act_t                act;

  // Tick captured at the input transfer.
  logic                              tick_rdy;
  logic [adcsa_pkg::DATA_BITS-1:0]   tick_data;

  // Sample store: one entry per channel and round. The valid bits stand for
  // the cleared value, so a reset or clear only touches the valid bits.
  logic [adcsa_pkg::DATA_BITS-1:0]   store_mem [adcsa_pkg::DEPTH];
  logic [adcsa_pkg::DEPTH-1:0]       store_vld;
  logic [adcsa_pkg::DATA_BITS-1:0]   rdata;
  logic                              rvld;

  // Averaging pass.
  logic [adcsa_pkg::CH_W-1:0]        sch;
  logic [adcsa_pkg::RD_W-1:0]        srd;
  logic [adcsa_pkg::ACC_W-1:0]       acc;

  // Output register.
  logic                              out_valid;
  logic [adcsa_pkg::ACT_W-1:0]       out_action;
  logic                              out_avg_valid;
  logic [adcsa_pkg::CH_W-1:0]        out_avg_channel;
  logic [adcsa_pkg::DATA_BITS-1:0]   out_avg_value;
  logic [adcsa_pkg::CNT_W-1:0]       out_reset_total;
  logic                              out_last;

  // Next values of one tick.
  adcsa_pkg::phase_t              phase_next;
  logic [adcsa_pkg::CH_W-1:0]     chan_next;
  logic [adcsa_pkg::RD_W-1:0]     rnd_next;
  logic [adcsa_pkg::CNT_W-1:0]    miss_next;
  logic [adcsa_pkg::CNT_W-1:0]    reset_count_next;
  adcsa_pkg::act_t                act_next;
  logic                           emit_next;
  logic                           wr_en;
  logic                           clr;
  logic                           out_free;
  logic [adcsa_pkg::IDX_W-1:0]    widx;
  logic [adcsa_pkg::IDX_W-1:0]    ridx;

  adcsa_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  assign in_ch.ready = ctl.take;
  assign out_free    = !out_valid || out_ch.ready;
  assign widx = adcsa_pkg::IDX_W'(32'(chan) * adcsa_pkg::ROUNDS + 32'(rnd));
  assign ridx = adcsa_pkg::IDX_W'(32'(sch) * adcsa_pkg::ROUNDS + 32'(srd));

  assign stat.in_fire  = in_ch.valid && in_ch.ready;
  assign stat.emit     = emit_next;
  assign stat.out_free = out_free;
  assign stat.rd_last  = (srd == adcsa_pkg::RD_W'(adcsa_pkg::ROUNDS - 1));
  assign stat.ch_last  = (sch == adcsa_pkg::CH_W'(adcsa_pkg::CHANNELS - 1));

  // One tick of the conversion sequence.
  always_comb begin
    phase_next       = phase;
    chan_next        = chan;
    rnd_next         = rnd;
    miss_next        = miss_count;
    reset_count_next = reset_count;
    act_next         = adcsa_pkg::ACT_BEGIN;
    emit_next        = 1'b0;
    wr_en            = 1'b0;
    clr              = 1'b0;
    unique case (phase)
      adcsa_pkg::PH_PULSE: begin
        phase_next = adcsa_pkg::PH_SETTLE;
        act_next   = adcsa_pkg::ACT_PULSE;
      end
      adcsa_pkg::PH_SETTLE: begin
        phase_next = adcsa_pkg::PH_READ;
        act_next   = adcsa_pkg::ACT_SETTLE;
      end
      adcsa_pkg::PH_READ: begin
        if (tick_rdy) begin
          miss_next = '0;
          if (tick_data != '0) begin
            wr_en    = 1'b1;
            act_next = adcsa_pkg::ACT_STORED;
          end else begin
            act_next = adcsa_pkg::ACT_ZERO;
          end
          if (chan == adcsa_pkg::CH_W'(adcsa_pkg::CHANNELS - 1)) begin
            chan_next  = '0;
            phase_next = adcsa_pkg::PH_IDLE;
            if (rnd == adcsa_pkg::RD_W'(adcsa_pkg::ROUNDS - 1)) begin
              rnd_next  = '0;
              emit_next = 1'b1;
            end else begin
              rnd_next = rnd + 1'b1;
            end
          end else begin
            chan_next  = chan + 1'b1;
            phase_next = adcsa_pkg::PH_PULSE;
          end
        end else if (miss_count >= miss_limit) begin
          clr        = 1'b1;
          phase_next = adcsa_pkg::PH_IDLE;
          chan_next  = '0;
          rnd_next   = '0;
          miss_next  = '0;
          if (reset_count != adcsa_pkg::CNT_MAX) begin
            reset_count_next = reset_count + 1'b1;
          end
          act_next = adcsa_pkg::ACT_RESET;
        end else begin
          miss_next = miss_count + 1'b1;
          act_next  = adcsa_pkg::ACT_WAITING;
        end
      end
      default: begin
        phase_next = adcsa_pkg::PH_PULSE;
        act_next   = adcsa_pkg::ACT_BEGIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_limit  <= adcsa_pkg::CNT_MAX;
      phase       <= adcsa_pkg::PH_IDLE;
      chan        <= '0;
      rnd         <= '0;
      miss_count  <= '0;
      reset_count <= '0;
      store_vld   <= '0;
    end else begin
      if (cfg_we) begin
        miss_limit <= cfg_wdata;
      end
      if (ctl.exec) begin
        phase       <= phase_next;
        chan        <= chan_next;
        rnd         <= rnd_next;
        miss_count  <= miss_next;
        reset_count <= reset_count_next;
        if (clr) begin
          store_vld <= '0;
        end else if (wr_en) begin
          store_vld[widx] <= 1'b1;
        end
      end
    end
  end

  // Store data, input capture and the averaging datapath.
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      store_mem[widx] <= tick_data;
    end
    if (ctl.rd_issue) begin
      rdata <= store_mem[ridx];
      rvld  <= store_vld[ridx];
    end
    if (stat.in_fire) begin
      tick_rdy  <= in_ch.data_ready;
      tick_data <= in_ch.adc_data;
    end
    if (ctl.exec) begin
      act <= act_next;
      sch <= '0;
      srd <= '0;
      acc <= '0;
    end
    if (ctl.acc_add) begin
      acc <= acc + (rvld ? adcsa_pkg::ACC_W'(rdata) : '0);
      srd <= stat.rd_last ? '0 : srd + 1'b1;
    end
    if (ctl.ch_step) begin
      acc <= '0;
      sch <= stat.ch_last ? '0 : sch + 1'b1;
    end
  end

  // Output register; it frees itself when the sink takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load && out_free) begin
      out_action      <= act;
      out_avg_valid   <= ctl.out_avg;
      out_avg_channel <= ctl.out_avg ? sch : '0;
      out_avg_value   <= ctl.out_avg ? acc[adcsa_pkg::ACC_W-1:adcsa_pkg::RD_W] : '0;
      out_reset_total <= reset_count;
      out_last        <= ctl.out_avg ? stat.ch_last : 1'b1;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.action      = out_action;
  assign out_ch.avg_valid   = out_avg_valid;
  assign out_ch.avg_channel = out_avg_channel;
  assign out_ch.avg_value   = out_avg_value;
  assign out_ch.reset_total = out_reset_total;
  assign out_ch.last        = out_last;

`ifndef SYNTHESIS
  // An accepted tick is executed on the very next cycle.
  a_fire_exec: assert property (@(posedge clk) disable iff (rst)
    stat.in_fire |=> ctl.exec)
    else $error("accepted tick not executed");

  // Averages are only started by a ready read of the last channel.
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && emit_next) |-> (phase == adcsa_pkg::PH_READ) && tick_rdy)
    else $error("averaging pass started outside a closing read");

  // A converter reset leaves an empty store and a restarted scan.
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && clr) |=> (store_vld == '0) && (chan == '0) && (rnd == '0)
      && (phase == adcsa_pkg::PH_IDLE))
    else $error("converter reset did not clear the sequence");
`endif

endmodule

// File: tb/sv/adcsa_scan_predictor.sv
`timescale 1ns / 1ps

// Watches the tick and result channels, keeps a cycle-free model of the scan
// sequencer and compares every result transfer with the oldest prediction.
module adcsa_scan_predictor
  import adcsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  adcsa_in_if              tick_bus,
  adcsa_out_if             result_bus,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output int               pending,
  output int               fail_count,
  output int               tick_total,
  output int               result_total,
  output int               average_total,
  output int               zero_total,
  output int               miss_total,
  output int               reset_seen
);

  typedef struct packed {
    act_t                 action;
    logic                 avg_valid;
    logic [CH_W-1:0]      avg_channel;
    logic [DATA_BITS-1:0] avg_value;
    logic [CNT_W-1:0]     reset_total;
    logic                 last;
  } tick_result_t;

  tick_result_t         expected_q[$];

  phase_t               seq_phase;
  logic [CH_W-1:0]      scan_ch;
  logic [RD_W-1:0]      scan_round;
  logic [DATA_BITS-1:0] samples [DEPTH];
  logic [CNT_W-1:0]     miss_run;
  logic [CNT_W-1:0]     conv_resets;
  logic [CNT_W-1:0]     miss_limit_r;

  initial begin
    pending       = 0;
    fail_count    = 0;
    tick_total    = 0;
    result_total  = 0;
    average_total = 0;
    zero_total    = 0;
    miss_total    = 0;
    reset_seen    = 0;
  end

  function automatic void clear_scan();
    seq_phase  = PH_IDLE;
    scan_ch    = '0;
    scan_round = '0;
    foreach (samples[i]) samples[i] = '0;
  endfunction

  function automatic void push_result(act_t act, logic v, logic [CH_W-1:0] ch,
                                      logic [DATA_BITS-1:0] val, logic lst);
    tick_result_t r;
    r.action      = act;
    r.avg_valid   = v;
    r.avg_channel = ch;
    r.avg_value   = val;
    r.reset_total = conv_resets;
    r.last        = lst;
    expected_q.push_back(r);
  endfunction

  // One tick of the conversion sequence; queues the results it causes.
  function automatic void step_sequencer(logic dr, logic [DATA_BITS-1:0] word);
    act_t             act;
    logic             emit;
    logic [ACC_W-1:0] sum;
    emit = 1'b0;
    case (seq_phase)
      PH_PULSE: begin
        seq_phase = PH_SETTLE;
        act       = ACT_PULSE;
      end
      PH_SETTLE: begin
        seq_phase = PH_READ;
        act       = ACT_SETTLE;
      end
      PH_READ: begin
        if (dr) begin
          miss_run = '0;
          if (word != '0) begin
            samples[int'(scan_ch) * ROUNDS + int'(scan_round)] = word;
            act = ACT_STORED;
          end else begin
            act = ACT_ZERO;
          end
          if (int'(scan_ch) == CHANNELS - 1) begin
            scan_ch   = '0;
            seq_phase = PH_IDLE;
            if (int'(scan_round) == ROUNDS - 1) begin
              scan_round = '0;
              emit       = 1'b1;
            end else begin
              scan_round = scan_round + 1'b1;
            end
          end else begin
            scan_ch   = scan_ch + 1'b1;
            seq_phase = PH_PULSE;
          end
        end else if (miss_run >= miss_limit_r) begin
          clear_scan();
          miss_run = '0;
          if (conv_resets != CNT_MAX) conv_resets = conv_resets + 1'b1;
          act = ACT_RESET;
        end else begin
          miss_run = miss_run + 1'b1;
          act      = ACT_WAITING;
        end
      end
      default: begin
        seq_phase = PH_PULSE;
        act       = ACT_BEGIN;
      end
    endcase

    tick_total++;
    if (act == ACT_ZERO) zero_total++;
    if (act == ACT_WAITING) miss_total++;
    if (act == ACT_RESET) reset_seen++;

    if (!emit) begin
      push_result(act, 1'b0, '0, '0, 1'b1);
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum = '0;
        for (int r = 0; r < ROUNDS; r++) sum = sum + samples[c * ROUNDS + r];
        push_result(act, 1'b1, CH_W'(c), DATA_BITS'(sum / ROUNDS), c == CHANNELS - 1);
      end
      average_total += CHANNELS;
    end
  endfunction

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (rst) begin
      clear_scan();
      miss_run     = '0;
      conv_resets  = '0;
      miss_limit_r = CNT_MAX;
      expected_q.delete();
    end else begin
      if (cfg_we) miss_limit_r = cfg_wdata;

      if (tick_bus.valid && tick_bus.ready)
        step_sequencer(tick_bus.data_ready, tick_bus.adc_data);

      if (result_bus.valid && result_bus.ready) begin
        result_total++;
        got.action      = act_t'(result_bus.action);
        got.avg_valid   = result_bus.avg_valid;
        got.avg_channel = result_bus.avg_channel;
        got.avg_value   = result_bus.avg_value;
        got.reset_total = result_bus.reset_total;
        got.last        = result_bus.last;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result act=%0d avg=%0b ch=%0d val=%h resets=%0d last=%0b",
                     $realtime, got.action, got.avg_valid, got.avg_channel,
                     got.avg_value, got.reset_total, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got.action !== want.action || got.avg_valid !== want.avg_valid ||
              got.avg_channel !== want.avg_channel || got.avg_value !== want.avg_value ||
              got.reset_total !== want.reset_total || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected act=%0d avg=%0b ch=%0d val=%h resets=%0d last=%0b",
                       want.action, want.avg_valid, want.avg_channel, want.avg_value,
                       want.reset_total, want.last);
              $display("  actual   act=%0d avg=%0b ch=%0d val=%h resets=%0d last=%0b",
                       got.action, got.avg_valid, got.avg_channel, got.avg_value,
                       got.reset_total, got.last);
            end
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Top of the sequencer testbench. This module only makes stimulus and gives
// the verdict; prediction and comparison live in adcsa_scan_predictor, which
// watches the same channels and hands back its failure count.
module tb_top;
  import adcsa_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  // Set while a phase runs with no gaps on either side of the block.
  bit               no_idle;

  int pending_n;
  int fail_n;
  int ticks_n;
  int results_n;
  int averages_n;
  int zeros_n;
  int misses_n;
  int resets_n;

  adcsa_in_if  in_if ();
  adcsa_out_if out_if ();

  adc_scan_average_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  adcsa_scan_predictor scan_pred (
    .clk           (clk),
    .rst           (rst),
    .tick_bus      (in_if),
    .result_bus    (out_if),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pending       (pending_n),
    .fail_count    (fail_n),
    .tick_total    (ticks_n),
    .result_total  (results_n),
    .average_total (averages_n),
    .zero_total    (zeros_n),
    .miss_total    (misses_n),
    .reset_seen    (resets_n)
  );

  // 20 ns clock, starting low.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Gap lengths, drawn from three ranges: mostly the shortest, sometimes the middle one, rarely the longest.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 11) return $urandom_range(1, 2);
    else if (r < 15) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // Conversion words with weight on the corners: zero (which the block must
  // discard), full scale, tiny values and single set bits.
  function automatic logic [DATA_BITS-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {DATA_BITS{1'b1}};
      2:       return DATA_BITS'($urandom_range(1, 15));
      3:       return DATA_BITS'(1) << $urandom_range(0, DATA_BITS - 1);
      default: return DATA_BITS'($urandom);
    endcase
  endfunction

  // Result side back-pressure. The receiver alternates between runs of ready
  // and stalls of random length; in a no-idle phase it simply stays ready.
  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_if.ready <= 1'b1;
        hold = 0;
      end else if (hold != 0) begin
        hold--;
      end else if (out_if.ready) begin
        out_if.ready <= 1'b0;
        hold = gap_len() - 1;
      end else begin
        out_if.ready <= 1'b1;
        hold = $urandom_range(0, 12);
      end
    end
  end

  // One tick transfer. Called at a falling edge and returns at a falling edge
  // with valid still high, so back-to-back ticks never lower and raise valid
  // in the same time step. A gap, when one is drawn, drops valid first.
  task automatic send_tick(input logic dr, input logic [DATA_BITS-1:0] word);
    int g;
    g = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_ready <= dr;
    in_if.adc_data   <= word;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has been taken. The
  // extra cycles let the last result register settle before anything else.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_n != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // The miss limit is only written while the block has nothing in flight.
  task automatic set_miss_limit(input logic [CNT_W-1:0] lim);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A stretch of random ticks. Ticks outside the read phase ignore both
  // fields; on reads, ready_pct sets how often a result is available, and
  // full_scale biases the words toward the largest value so that averages
  // of four full-scale samples come out.
  task automatic run_ticks(input int n, input int ready_pct, input bit full_scale);
    logic                 dr;
    logic [DATA_BITS-1:0] word;
    for (int i = 0; i < n; i++) begin
      dr = ($urandom_range(0, 99) < ready_pct);
      if (full_scale && $urandom_range(0, 3) != 0) word = {DATA_BITS{1'b1}};
      else word = rand_word();
      send_tick(dr, word);
    end
  endtask

  // Walk idle, start pulse and settle so that the next tick is a read.
  task automatic walk_to_read(input int ticks);
    for (int i = 0; i < ticks; i++) send_tick(1'($urandom_range(0, 1)), rand_word());
  endtask

  initial begin
    int spin;

    // Every input is known from time zero, with reset asserted.
    rst              = 1'b1;
    no_idle          = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.data_ready = 1'b0;
    in_if.adc_data   = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The limit starts at its largest value so that misses
    // only count up.
    set_miss_limit(CNT_MAX);
    send_tick(1'b0, '0);                   // idle: begin conversion
    send_tick(1'b1, {DATA_BITS{1'b1}});    // start pulse
    send_tick(1'b0, {DATA_BITS{1'b1}});    // settle
    repeat (3) send_tick(1'b0, {DATA_BITS{1'b1}});  // not ready: waiting
    send_tick(1'b1, {DATA_BITS{1'b1}});    // channel 0 stores full scale
    walk_to_read(2);
    send_tick(1'b1, '0);                   // channel 1 reads zero: discarded
    walk_to_read(2);
    send_tick(1'b1, DATA_BITS'(1));        // channel 2 stores one, round ends
    walk_to_read(3);
    repeat (2) send_tick(1'b0, DATA_BITS'($urandom));

    // Lowering the limit below the running miss count makes the very next
    // not-ready read request a converter reset.
    set_miss_limit(CNT_W'(1));
    send_tick(1'b0, '0);

    // With a limit of zero the first not-ready read already resets.
    set_miss_limit('0);
    walk_to_read(3);
    send_tick(1'b0, DATA_BITS'($urandom));
    walk_to_read(3);
    send_tick(1'b1, DATA_BITS'(24'h800000));

    // Random part, in phases with different limits and ready rates. Most
    // reads see data so that full four-round scans complete and emit their
    // averages; the misses that slip in drive the reset path.
    set_miss_limit(CNT_MAX);
    run_ticks(90, 90, 1'b1);

    set_miss_limit(CNT_W'(1));
    no_idle = 1'b1;
    run_ticks(70, 85, 1'b0);
    drain_results();
    no_idle = 1'b0;

    set_miss_limit('0);
    run_ticks(40, 97, 1'b0);

    set_miss_limit(CNT_W'(3));
    run_ticks(80, 75, 1'b0);

    // Mid-phase, the sender holds off until every result has come back.
    set_miss_limit(CNT_W'($urandom_range(4, 200)));
    run_ticks(60, 92, 1'b0);
    drain_results();
    run_ticks(60, 92, 1'b0);

    // Wind down: wait for the last results, with a bound, then let the
    // block sit for longer than one averaging pass.
    in_if.valid <= 1'b0;
    spin = 0;
    while (pending_n != 0 && spin < 100000) begin
      @(negedge clk);
      spin++;
    end
    repeat (40) @(negedge clk);

    if (pending_n != 0)
      $display("%0d predicted results never arrived", pending_n);
    $display("Covered %0d ticks and %0d result transfers, %0d of them channel averages.",
             ticks_n, results_n, averages_n);
    $display("Reads saw %0d zero words and %0d misses; %0d converter resets requested.",
             zeros_n, misses_n, resets_n);
    if (fail_n == 0 && pending_n == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
